@@ hdl/sot_pkg.sv @@
// Shared types and codes for the segment offset translator.
// Holds request function codes, result status codes and parameter defaults.
// No dependencies.
package sot_pkg;

  // Parameter defaults
  localparam int unsigned MAX_SEGMENTS_DEF = 16;
  localparam int unsigned ADDR_BITS_DEF    = 48;

  // Request function codes
  typedef logic [1:0] func_t;
  localparam func_t FUNC_CLEAR  = 2'd0;
  localparam func_t FUNC_APPEND = 2'd1;
  localparam func_t FUNC_L2P    = 2'd2;
  localparam func_t FUNC_P2L    = 2'd3;

  // Result status codes
  typedef logic [2:0] status_t;
  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_RANGE     = 3'd1;
  localparam status_t ST_SOURCE    = 3'd2;
  localparam status_t ST_OVERFLOW  = 3'd3;
  localparam status_t ST_FULL      = 3'd4;
  localparam status_t ST_NOT_FOUND = 3'd5;

endpackage

@@ hdl/sot_seg_table.sv @@
// Segment table storage: one write port, one read port, registered read data.
// Entries are undefined until written. Used by segment_offset_translator.
module sot_seg_table #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned DATA_W = 192,
  parameter int unsigned IDX_W  = 4
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [IDX_W-1:0]  waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [IDX_W-1:0]  raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // Write entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read entry, registered
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/segment_offset_translator.sv @@
// Latency: clear, append and requests decided without a table walk give one result
// in the cycle after acceptance; busy stays low, so a new request can follow at once.
// Walking requests read one segment table entry per cycle from the table memory:
// the read data is registered, each result is registered, and busy stays high until the
// entry that ends the request has been read; no new request is taken while busy.
// Reset empties the table and clears source_size; the receiver cannot stall results.
module segment_offset_translator #(
  parameter int unsigned MAX_SEGMENTS = sot_pkg::MAX_SEGMENTS_DEF,
  parameter int unsigned ADDR_BITS    = sot_pkg::ADDR_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  source_size_we_i,
  input  logic [ADDR_BITS-1:0]  source_size_i,
  input  logic                  start,
  output logic                  busy,
  input  sot_pkg::func_t        func_i,
  input  logic [ADDR_BITS-1:0]  address_i,
  input  logic [ADDR_BITS-1:0]  span_len_i,
  output logic                  result_valid_o,
  output sot_pkg::status_t      status_o,
  output logic                  span_valid_o,
  output logic [ADDR_BITS-1:0]  phys_offset_o,
  output logic [ADDR_BITS-1:0]  out_length_o,
  output logic [ADDR_BITS-1:0]  logical_result_o,
  output logic                  last_o
);

  import sot_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned ENT_W = 4 * ADDR_BITS;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WALK = 1'b1;

  localparam logic [1:0] WALK_ZERO = 2'd0;
  localparam logic [1:0] WALK_SPAN = 2'd1;
  localparam logic [1:0] WALK_PHYS = 2'd2;

  // One table entry; delta is physical base minus logical start
  typedef struct packed {
    logic [ADDR_BITS-1:0] pbase;
    logic [ADDR_BITS-1:0] pend;
    logic [ADDR_BITS-1:0] lend;
    logic [ADDR_BITS-1:0] delta;
  } seg_entry_t;

  logic [ADDR_BITS-1:0] src_q;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [ADDR_BITS-1:0] total_q, total_d;
  logic                 state_q, state_d;
  logic [1:0]           walk_op_q, walk_op_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [ADDR_BITS-1:0] addr_q, addr_d;
  logic [ADDR_BITS-1:0] pos_q, pos_d;
  logic [ADDR_BITS-1:0] qend_q, qend_d;

  logic                 res_valid_q;
  status_t              status_q;
  logic                 span_q;
  logic [ADDR_BITS-1:0] phys_q, len_q, logic_q;
  logic                 last_q;

  logic                 emit;
  status_t              e_status;
  logic                 e_span;
  logic [ADDR_BITS-1:0] e_phys, e_len, e_logic;
  logic                 e_last;

  logic                 mem_we;
  seg_entry_t           wr_entry;
  logic [IDX_W-1:0]     rd_addr;
  logic [ENT_W-1:0]     rd_data;
  seg_entry_t           rd_entry;

  logic                 accept;
  logic [ADDR_BITS:0]   app_sum;
  logic                 app_src_err;
  logic                 table_full;
  logic                 rng_err;
  logic                 last_idx;
  logic                 fin;

  assign accept   = start && (state_q == S_IDLE);
  assign rd_entry = seg_entry_t'(rd_data);

  // Append checks
  assign app_sum     = {1'b0, total_q} + {1'b0, span_len_i};
  assign app_src_err = (address_i > src_q) || (span_len_i > (src_q - address_i));
  assign table_full  = (count_q >= CNT_W'(MAX_SEGMENTS));

  // Logical query range check
  assign rng_err = (address_i > total_q) || (span_len_i > (total_q - address_i));

  // Walk position helpers
  assign last_idx = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
  assign fin      = (qend_q <= rd_entry.lend);

  // Read the entry for the next walk step
  always_comb begin
    if (state_q == S_IDLE) begin
      rd_addr = '0;
    end else if (idx_q == IDX_W'(MAX_SEGMENTS - 1)) begin
      rd_addr = idx_q;
    end else begin
      rd_addr = idx_q + IDX_W'(1);
    end
  end

  // Request decode and table walk
  always_comb begin
    count_d   = count_q;
    total_d   = total_q;
    state_d   = state_q;
    walk_op_d = walk_op_q;
    idx_d     = idx_q;
    addr_d    = addr_q;
    pos_d     = pos_q;
    qend_d    = qend_q;
    emit      = 1'b0;
    e_status  = ST_OK;
    e_span    = 1'b0;
    e_phys    = '0;
    e_len     = '0;
    e_logic   = '0;
    e_last    = 1'b1;
    mem_we    = 1'b0;

    wr_entry.pbase = address_i;
    wr_entry.pend  = address_i + span_len_i;
    wr_entry.lend  = app_sum[ADDR_BITS-1:0];
    wr_entry.delta = address_i - total_q;

    if (accept) begin
      addr_d = address_i;
      pos_d  = address_i;
      qend_d = address_i + span_len_i;
      idx_d  = '0;
      case (func_i)
        FUNC_CLEAR: begin
          count_d = '0;
          total_d = '0;
          emit    = 1'b1;
        end
        FUNC_APPEND: begin
          emit = 1'b1;
          if (app_src_err) begin
            e_status = ST_SOURCE;
          end else if (app_sum[ADDR_BITS]) begin
            e_status = ST_OVERFLOW;
          end else if ((span_len_i != '0) && table_full) begin
            e_status = ST_FULL;
          end else begin
            total_d = app_sum[ADDR_BITS-1:0];
            if (span_len_i != '0) begin
              mem_we  = 1'b1;
              count_d = count_q + CNT_W'(1);
            end
          end
        end
        FUNC_L2P: begin
          if (rng_err) begin
            emit     = 1'b1;
            e_status = ST_RANGE;
          end else if (count_q == '0) begin
            emit     = 1'b1;
            e_status = (span_len_i == '0) ? ST_OK : ST_NOT_FOUND;
          end else begin
            state_d   = S_WALK;
            walk_op_d = (span_len_i == '0) ? WALK_ZERO : WALK_SPAN;
          end
        end
        FUNC_P2L: begin
          if (count_q == '0) begin
            emit     = 1'b1;
            e_status = ST_NOT_FOUND;
          end else begin
            state_d   = S_WALK;
            walk_op_d = WALK_PHYS;
          end
        end
        default: ;
      endcase
    end else if (state_q == S_WALK) begin
      idx_d = idx_q + IDX_W'(1);
      case (walk_op_q)
        WALK_ZERO: begin
          // Anchor at the first segment holding the offset or ending at the last one
          if ((addr_q < rd_entry.lend) || ((addr_q == rd_entry.lend) && last_idx)) begin
            emit    = 1'b1;
            e_span  = 1'b1;
            e_phys  = addr_q + rd_entry.delta;
            state_d = S_IDLE;
          end else if (last_idx) begin
            emit    = 1'b1;
            state_d = S_IDLE;
          end
        end
        WALK_SPAN: begin
          if (pos_q >= rd_entry.lend) begin
            // Skip segments before the position
            if (last_idx) begin
              emit     = 1'b1;
              e_status = ST_NOT_FOUND;
              state_d  = S_IDLE;
            end
          end else begin
            emit   = 1'b1;
            e_span = 1'b1;
            e_phys = pos_q + rd_entry.delta;
            e_len  = fin ? (qend_q - pos_q) : (rd_entry.lend - pos_q);
            e_last = fin || last_idx;
            pos_d  = rd_entry.lend;
            if (fin || last_idx) begin
              state_d = S_IDLE;
            end
          end
        end
        WALK_PHYS: begin
          if ((addr_q >= rd_entry.pbase) && (addr_q < rd_entry.pend)) begin
            emit    = 1'b1;
            e_logic = addr_q - rd_entry.delta;
            state_d = S_IDLE;
          end else if (last_idx) begin
            emit    = 1'b1;
            state_d = S_IDLE;
            if (addr_q == rd_entry.pend) begin
              e_logic = total_q;
            end else begin
              e_status = ST_NOT_FOUND;
            end
          end
        end
        default: begin
          state_d = S_IDLE;
        end
      endcase
    end
  end

  sot_seg_table #(
    .DEPTH  (MAX_SEGMENTS),
    .DATA_W (ENT_W),
    .IDX_W  (IDX_W)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (wr_entry),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q       <= '0;
      count_q     <= '0;
      total_q     <= '0;
      state_q     <= S_IDLE;
      walk_op_q   <= WALK_ZERO;
      idx_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (source_size_we_i) begin
        src_q <= source_size_i;
      end
      count_q     <= count_d;
      total_q     <= total_d;
      state_q     <= state_d;
      walk_op_q   <= walk_op_d;
      idx_q       <= idx_d;
      res_valid_q <= emit;
    end
  end

  // Request operands and result payload
  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    pos_q  <= pos_d;
    qend_q <= qend_d;
    if (emit) begin
      status_q <= e_status;
      span_q   <= e_span;
      phys_q   <= e_phys;
      len_q    <= e_len;
      logic_q  <= e_logic;
      last_q   <= e_last;
    end
  end

  assign busy             = (state_q == S_WALK);
  assign result_valid_o   = res_valid_q;
  assign status_o         = status_q;
  assign span_valid_o     = span_q;
  assign phys_offset_o    = phys_q;
  assign out_length_o     = len_q;
  assign logical_result_o = logic_q;
  assign last_o           = last_q;

endmodule

@@ hdl/sot_checker.sv @@
// Port-level checks for segment_offset_translator, attached by bind.
// Depends on sot_pkg for status codes.
module sot_checker #(
  parameter int unsigned ADDR_BITS = sot_pkg::ADDR_BITS_DEF
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  source_size_we_i,
  input logic [ADDR_BITS-1:0]  source_size_i,
  input logic                  start,
  input logic                  busy,
  input sot_pkg::func_t        func_i,
  input logic [ADDR_BITS-1:0]  address_i,
  input logic [ADDR_BITS-1:0]  span_len_i,
  input logic                  result_valid_o,
  input sot_pkg::status_t      status_o,
  input logic                  span_valid_o,
  input logic [ADDR_BITS-1:0]  phys_offset_o,
  input logic [ADDR_BITS-1:0]  out_length_o,
  input logic [ADDR_BITS-1:0]  logical_result_o,
  input logic                  last_o
);

  import sot_pkg::*;

  // An accepted request either answers next cycle or keeps the block busy
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> result_valid_o || busy)
    else $error("accepted request made no progress");

  // More results of the same request must follow while busy
  a_not_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |-> busy)
    else $error("non-final result while idle");

  // No result without a request in flight
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy) || $past(start))
    else $error("result without request");

  // A span only comes with a good status
  a_span_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && span_valid_o |-> status_o == ST_OK)
    else $error("span with error status");

endmodule

bind segment_offset_translator sot_checker #(.ADDR_BITS(ADDR_BITS)) u_sot_checker (.*);
